### rtl/mwfd_pkg.sv
// Shared constants and types for the fetch-to-decode queue.
// No dependencies; mwfd_cfg, mwfd_ctrl and the top level refer to it by scoped names.
package mwfd_pkg;

  localparam int unsigned Depth      = 16;
  localparam int unsigned EntryBits  = 64;
  localparam int unsigned PtrW       = 4;
  localparam int unsigned CntW       = 5;
  localparam int unsigned BankDepth  = Depth / 2;
  localparam int unsigned BankAw     = 3;
  localparam int unsigned InBits     = 136;
  localparam int unsigned OutBits    = 144;
  localparam int unsigned AddrW      = 4;
  localparam int unsigned DataW      = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] RegQueueCap = 2'd0;
  localparam logic [1:0] RegPushW    = 2'd1;
  localparam logic [1:0] RegPopW     = 2'd2;

  typedef struct packed {
    logic [4:0] queue_capacity;
    logic [1:0] push_width;
    logic [1:0] pop_width;
  } cfg_t;

  typedef struct packed {
    logic       flush;
    logic       be_ready;
    logic       out_space;
    logic       in_valid;
    logic [1:0] in_count;
  } in_ctl_t;

  typedef struct packed {
    logic              out_valid;
    logic [1:0]        out_count;
    logic              accept_ready;
    logic              took_input;
    logic              overflow_stall;
    logic [CntW-1:0]   occupancy;
    logic [CntW-1:0]   peak_occupancy;
    logic              head_odd;
  } res_t;

  typedef struct packed {
    logic [BankAw-1:0] rd_addr;
    logic              we;
    logic [BankAw-1:0] wr_addr;
    logic              wr_sel;
  } bank_ctl_t;

endpackage

### rtl/mwfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mwfd_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mwfd_cfg.sv
// APB register file: queue capacity, push width, pop width.
// Depends on mwfd_pkg.
module mwfd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mwfd_pkg::AddrW-1:0]  paddr,
  input  logic [mwfd_pkg::DataW-1:0]  pwdata,
  output logic [mwfd_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output mwfd_pkg::cfg_t              cfg_o
);

  mwfd_pkg::cfg_t cfg_q;
  logic           wr_en;
  logic [1:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.queue_capacity <= 5'd16;
      cfg_q.push_width     <= 2'd2;
      cfg_q.pop_width      <= 2'd2;
    end else if (wr_en) begin
      unique case (idx)
        mwfd_pkg::RegQueueCap: cfg_q.queue_capacity <= pwdata[4:0];
        mwfd_pkg::RegPushW:    cfg_q.push_width     <= pwdata[1:0];
        mwfd_pkg::RegPopW:     cfg_q.pop_width      <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      mwfd_pkg::RegQueueCap: prdata[4:0] = cfg_q.queue_capacity;
      mwfd_pkg::RegPushW:    prdata[1:0] = cfg_q.push_width;
      mwfd_pkg::RegPopW:     prdata[1:0] = cfg_q.pop_width;
      default:               prdata      = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/mwfd_ctrl.sv
// Queue bookkeeping: head, count, ready flag, peak; pop/push decisions
// and per-bank RAM addressing. Depends on mwfd_pkg.
module mwfd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  mwfd_pkg::in_ctl_t     in_i,
  input  mwfd_pkg::cfg_t        cfg_i,
  output mwfd_pkg::res_t        res_o,
  output mwfd_pkg::bank_ctl_t   bank0_o,
  output mwfd_pkg::bank_ctl_t   bank1_o
);

  logic [mwfd_pkg::PtrW-1:0] head_q, head_d, head_mid, tail, tail_p1, head_rd0;
  logic [mwfd_pkg::CntW-1:0] count_q, count_d, count_mid, cap, peak_q, peak_d;
  logic                      ready_q, ready_d, ready_new;
  logic [1:0]                pw, dw, n_pop, n_push;
  logic                      pop_go, push_go;
  logic [mwfd_pkg::CntW:0]   need;

  // clamp widths to 1..2
  always_comb begin
    pw = (cfg_i.push_width == 2'd0) ? 2'd1 :
         (cfg_i.push_width > 2'd2) ? 2'd2 : cfg_i.push_width;
    dw = (cfg_i.pop_width == 2'd0) ? 2'd1 :
         (cfg_i.pop_width > 2'd2) ? 2'd2 : cfg_i.pop_width;
    cap = (cfg_i.queue_capacity > 5'd16) ? 5'd16 : cfg_i.queue_capacity;
  end

  always_comb begin
    pop_go    = in_i.be_ready & in_i.out_space & (count_q != '0);
    n_pop     = '0;
    if (pop_go) begin
      n_pop = (count_q < {3'b0, dw}) ? count_q[1:0] : dw;
    end
    count_mid = count_q - {3'b0, n_pop};
    head_mid  = head_q + {2'b0, n_pop};
    need      = {1'b0, count_mid} + {4'b0, pw};
    ready_new = ({1'b0, cap} >= need);
    push_go   = ready_new & in_i.in_valid;
    n_push    = '0;
    if (push_go) begin
      n_push = (in_i.in_count > pw) ? pw : in_i.in_count;
    end
    tail    = head_mid + count_mid[mwfd_pkg::PtrW-1:0];
    tail_p1 = tail + 4'd1;
  end

  // next state and result
  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    ready_d = ready_q;
    peak_d  = peak_q;
    res_o   = '0;
    res_o.head_odd = head_q[0];
    if (in_i.flush) begin
      head_d  = '0;
      count_d = '0;
      res_o.accept_ready   = ready_q;
      res_o.took_input     = in_i.in_valid;
      res_o.peak_occupancy = peak_q;
    end else begin
      head_d  = head_mid;
      count_d = count_mid + {3'b0, n_push};
      ready_d = ready_new;
      if (push_go && (count_d > peak_q)) begin
        peak_d = count_d;
      end
      res_o.out_valid      = pop_go;
      res_o.out_count      = n_pop;
      res_o.accept_ready   = ready_new;
      res_o.took_input     = push_go;
      res_o.overflow_stall = ~ready_new & in_i.in_valid;
      res_o.occupancy      = count_d;
      res_o.peak_occupancy = peak_d;
    end
  end

  // even entries in bank 0, odd entries in bank 1
  always_comb begin
    head_rd0        = head_q + {3'b0, head_q[0]};
    bank0_o.rd_addr = head_rd0[3:1];
    bank1_o.rd_addr = head_q[3:1];
    if (!tail[0]) begin
      bank0_o.we      = ~in_i.flush & (n_push != 2'd0);
      bank0_o.wr_addr = tail[3:1];
      bank0_o.wr_sel  = 1'b0;
      bank1_o.we      = ~in_i.flush & (n_push == 2'd2);
      bank1_o.wr_addr = tail[3:1];
      bank1_o.wr_sel  = 1'b1;
    end else begin
      bank1_o.we      = ~in_i.flush & (n_push != 2'd0);
      bank1_o.wr_addr = tail[3:1];
      bank1_o.wr_sel  = 1'b0;
      bank0_o.we      = ~in_i.flush & (n_push == 2'd2);
      bank0_o.wr_addr = tail_p1[3:1];
      bank0_o.wr_sel  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      ready_q <= 1'b1;
      peak_q  <= '0;
    end else if (accept_i) begin
      head_q  <= head_d;
      count_q <= count_d;
      ready_q <= ready_d;
      peak_q  <= peak_d;
    end
  end

endmodule

### rtl/multi_width_fetch_decode_fifo.sv
// Top level of the fetch-to-decode queue: stream ports, APB registers,
// two interleaved entry banks. Depends on mwfd_pkg, mwfd_cfg, mwfd_ctrl, mwfd_ram.
//
// Usage:
//  - Each beat on the s_axis channel is one tick of the queue: flush and
//    backend/space flags, plus an optional fetch bundle of up to two entries.
//  - Each tick yields exactly one beat on m_axis: the popped bundle (unused
//    entry lanes read zero), ready-to-fetch, took/stall flags, occupancy
//    and peak occupancy.
//  - Throughput: one beat per cycle while m_axis does not stall. The queue
//    state, the result fields and the bank read data all register at the
//    accept edge, and the output register then loads the finished beat.
//  - Entries live in two 8-deep banks (even and odd slots), so a two-entry
//    pop and a two-entry push each touch every bank at most once.
//  - When m_axis stalls, the output register and the result stage hold;
//    s_axis_tready drops only once both are full.
//  - Reset empties the queue, sets ready-to-fetch, clears peak, and loads
//    capacity 16, push width 2, pop width 2. Write registers only while idle.
module multi_width_fetch_decode_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata, low bit up: flush, be_ready, out_space, in_valid,
  // in_count[1:0], in_entry0[63:0], in_entry1[63:0], 2 pad bits
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mwfd_pkg::InBits-1:0]   s_axis_tdata,
  // tdata, low bit up: out_valid, out_count[1:0], out_entry0[63:0],
  // out_entry1[63:0], accept_ready, took_input, overflow_stall,
  // occupancy[4:0], peak_occupancy[4:0]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mwfd_pkg::OutBits-1:0]  m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwfd_pkg::AddrW-1:0]    paddr,
  input  logic [mwfd_pkg::DataW-1:0]    pwdata,
  output logic [mwfd_pkg::DataW-1:0]    prdata,
  output logic                          pready
);

  mwfd_pkg::cfg_t      cfg;
  mwfd_pkg::in_ctl_t   in_ctl;
  mwfd_pkg::res_t      res, res_q;
  mwfd_pkg::bank_ctl_t bank0, bank1;

  logic                              s_fire, p_adv, p_valid_q, m_valid_q;
  logic [mwfd_pkg::EntryBits-1:0]    pay0, pay1, wd0, wd1, rd0, rd1, e0, e1;
  logic [mwfd_pkg::OutBits-1:0]      m_data_q, m_data_d;

  assign in_ctl.flush         = s_axis_tdata[0];
  assign in_ctl.be_ready      = s_axis_tdata[1];
  assign in_ctl.out_space     = s_axis_tdata[2];
  assign in_ctl.in_valid      = s_axis_tdata[3];
  assign in_ctl.in_count      = s_axis_tdata[5:4];
  assign pay0                 = s_axis_tdata[69:6];
  assign pay1                 = s_axis_tdata[133:70];

  // advance the result stage when the output register is free or draining
  assign p_adv         = ~m_valid_q | m_axis_tready;
  assign s_axis_tready = ~p_valid_q | p_adv;
  assign s_fire        = s_axis_tvalid & s_axis_tready;

  mwfd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mwfd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_fire),
    .in_i     (in_ctl),
    .cfg_i    (cfg),
    .res_o    (res),
    .bank0_o  (bank0),
    .bank1_o  (bank1)
  );

  assign wd0 = bank0.wr_sel ? pay1 : pay0;
  assign wd1 = bank1.wr_sel ? pay1 : pay0;

  // read data holds while the result stage is stalled (read only on accept)
  mwfd_ram #(
    .Width (mwfd_pkg::EntryBits),
    .Depth (mwfd_pkg::BankDepth)
  ) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (s_fire & bank0.we),
    .waddr_i (bank0.wr_addr),
    .wdata_i (wd0),
    .re_i    (s_fire),
    .raddr_i (bank0.rd_addr),
    .rdata_o (rd0)
  );

  mwfd_ram #(
    .Width (mwfd_pkg::EntryBits),
    .Depth (mwfd_pkg::BankDepth)
  ) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (s_fire & bank1.we),
    .waddr_i (bank1.wr_addr),
    .wdata_i (wd1),
    .re_i    (s_fire),
    .raddr_i (bank1.rd_addr),
    .rdata_o (rd1)
  );

  // result stage: control fields beside the bank read registers
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        p_valid_q <= s_fire;
      end
      if (p_adv) begin
        m_valid_q <= p_valid_q;
      end
    end
  end

  // rotate lanes by head parity; drop entries beyond out_count
  always_comb begin
    e0 = res_q.head_odd ? rd1 : rd0;
    e1 = res_q.head_odd ? rd0 : rd1;
    if (res_q.out_count == 2'd0) begin
      e0 = '0;
    end
    if (res_q.out_count != 2'd2) begin
      e1 = '0;
    end
    m_data_d = {res_q.peak_occupancy, res_q.occupancy, res_q.overflow_stall,
                res_q.took_input, res_q.accept_ready, e1, e0,
                res_q.out_count, res_q.out_valid};
  end

  always_ff @(posedge clk_i) begin
    if (p_adv && p_valid_q) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

### tb/tb_multi_width_fetch_decode_fifo.sv
// Self-checking testbench for the fetch-to-decode queue multi_width_fetch_decode_fifo.
// Drives ticks on s_axis, programs the APB registers and checks every m_axis beat.
// Depends on mwfd_pkg and the rtl sources only.
module tb_multi_width_fetch_decode_fifo;

  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned DrainCycles    = 8;
  localparam int unsigned SinkHoldCycles = 120;
  localparam int unsigned SlotCount      = 16;
  localparam int unsigned LaneCount      = 2;

  // One tick as the block sees it on s_axis.
  typedef struct packed {
    logic        flush;
    logic        be_ready;
    logic        out_space;
    logic        in_valid;
    logic [1:0]  in_count;
    logic [63:0] in_entry0;
    logic [63:0] in_entry1;
  } fetch_tick_t;

  // One decode beat as it leaves on m_axis.
  typedef struct packed {
    logic        out_valid;
    logic [1:0]  out_count;
    logic [63:0] out_entry0;
    logic [63:0] out_entry1;
    logic        accept_ready;
    logic        took_input;
    logic        overflow_stall;
    logic [4:0]  occupancy;
    logic [4:0]  peak_occupancy;
  } decode_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  // tdata, low bit up: flush, be_ready, out_space, in_valid,
  // in_count[1:0], in_entry0[63:0], in_entry1[63:0], 2 pad bits
  logic [mwfd_pkg::InBits-1:0]   s_axis_tdata  = '0;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  // tdata, low bit up: out_valid, out_count[1:0], out_entry0[63:0],
  // out_entry1[63:0], accept_ready, took_input, overflow_stall,
  // occupancy[4:0], peak_occupancy[4:0]
  logic [mwfd_pkg::OutBits-1:0]  m_axis_tdata;

  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [mwfd_pkg::AddrW-1:0]    paddr   = '0;
  logic [mwfd_pkg::DataW-1:0]    pwdata  = '0;
  logic [mwfd_pkg::DataW-1:0]    prdata;
  logic                          pready;

  // Shadow of the queue state, advanced once per accepted tick.
  logic [63:0] shadow_slots [SlotCount];
  logic [3:0]  shadow_head  = '0;
  logic [4:0]  shadow_fill  = '0;
  logic        shadow_ready = 1'b1;
  logic [4:0]  shadow_peak  = '0;

  // Shadow of the registers, reset values.
  logic [4:0]  cap_reg    = 5'd16;
  logic [1:0]  push_w_reg = 2'd2;
  logic [1:0]  pop_w_reg  = 2'd2;

  decode_beat_t decode_beats_due [$];

  int unsigned src_idle_pct  = 17;
  int unsigned sink_idle_pct = 17;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned sink_hold_left = 0;
  int unsigned cycle_count   = 0;

  int unsigned error_count   = 0;
  int unsigned ticks_sent    = 0;
  int unsigned beats_checked = 0;
  int unsigned stall_beats   = 0;
  int unsigned flush_ticks   = 0;
  int unsigned settings_used = 1;

  multi_width_fetch_decode_fifo DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Walk the queue through one tick: flush first, then pop, then the
  // acceptance decision against the reserved push width, then push.
  function automatic decode_beat_t predict_decode_beat(input fetch_tick_t t);
    decode_beat_t r;
    int unsigned  cap, pw, dw, n;
    logic [3:0]   slot;
    r   = '0;
    cap = (cap_reg > SlotCount) ? SlotCount : cap_reg;
    pw  = (push_w_reg == 0) ? 1 : ((push_w_reg > LaneCount) ? LaneCount : push_w_reg);
    dw  = (pop_w_reg == 0) ? 1 : ((pop_w_reg > LaneCount) ? LaneCount : pop_w_reg);
    if (t.flush) begin
      // ready flag and peak hold across a flush
      shadow_fill  = '0;
      shadow_head  = '0;
      r.took_input = t.in_valid;
    end else begin
      if (t.be_ready && t.out_space && shadow_fill != 0) begin
        n = (shadow_fill < dw) ? shadow_fill : dw;
        r.out_entry0 = shadow_slots[shadow_head];
        shadow_head  = shadow_head + 4'd1;
        if (n == 2) begin
          r.out_entry1 = shadow_slots[shadow_head];
          shadow_head  = shadow_head + 4'd1;
        end
        shadow_fill = shadow_fill - 5'(n);
        r.out_valid = 1'b1;
        r.out_count = 2'(n);
      end
      shadow_ready     = (cap >= shadow_fill + pw);
      r.overflow_stall = !shadow_ready && t.in_valid;
      if (shadow_ready && t.in_valid) begin
        // oversized bundles are cut to the push width; a zero count
        // consumes the bundle without storing anything
        n = (t.in_count > pw) ? pw : t.in_count;
        if (n >= 1) begin
          slot = shadow_head + shadow_fill[3:0];
          shadow_slots[slot] = t.in_entry0;
          shadow_fill = shadow_fill + 5'd1;
        end
        if (n == 2) begin
          slot = shadow_head + shadow_fill[3:0];
          shadow_slots[slot] = t.in_entry1;
          shadow_fill = shadow_fill + 5'd1;
        end
        r.took_input = 1'b1;
        if (shadow_fill > shadow_peak) shadow_peak = shadow_fill;
      end
    end
    r.accept_ready   = shadow_ready;
    r.occupancy      = shadow_fill;
    r.peak_occupancy = shadow_peak;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function automatic fetch_tick_t mk_tick(input logic flush, input logic br, input logic space,
                                          input logic valid, input logic [1:0] cnt,
                                          input logic [63:0] e0, input logic [63:0] e1);
    fetch_tick_t t;
    t = '{flush, br, space, valid, cnt, e0, e1};
    return t;
  endfunction

  function automatic fetch_tick_t random_tick(input int unsigned pop_pct);
    fetch_tick_t t;
    t.flush         = ($urandom_range(99) < 4);
    t.be_ready      = ($urandom_range(99) < pop_pct);
    t.out_space     = ($urandom_range(99) < 85);
    t.in_valid      = ($urandom_range(99) < 75);
    // mostly legal counts, now and then zero or an oversized three
    t.in_count      = ($urandom_range(9) == 0) ? 2'($urandom_range(1) * 3)
                                               : 2'($urandom_range(1, 2));
    t.in_entry0     = {$urandom, $urandom};
    t.in_entry1     = {$urandom, $urandom};
    return t;
  endfunction

  // Offer one tick, idling at random first; predict it once the beat is taken.
  task automatic send_tick(input fetch_tick_t t);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, t.in_entry1, t.in_entry0, t.in_count,
                      t.in_valid, t.out_space, t.be_ready, t.flush};
    do @(posedge clk_i); while (!s_axis_tready);
    decode_beats_due.insert(decode_beats_due.size(), predict_decode_beat(t));
    ticks_sent++;
    if (t.flush) flush_ticks++;
  endtask

  // Drop valid and hold until every predicted beat has been seen.
  task automatic wait_queue_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (decode_beats_due.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      mwfd_pkg::RegQueueCap: cap_reg    = value[4:0];
      mwfd_pkg::RegPushW:    push_w_reg = value[1:0];
      mwfd_pkg::RegPopW:     pop_w_reg  = value[1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [4:0] cap, input logic [1:0] pw,
                               input logic [1:0] dw);
    wait_queue_idle();
    write_reg(mwfd_pkg::RegQueueCap, 32'(cap));
    write_reg(mwfd_pkg::RegPushW, 32'(pw));
    write_reg(mwfd_pkg::RegPopW, 32'(dw));
    settings_used++;
  endtask

  // Reset defaults: clamped counts, zero counts, pop without space, flushes.
  task automatic test_directed_corners();
    send_tick(mk_tick(0, 0, 0, 0, 2'd0, 64'h0, 64'h0));
    send_tick(mk_tick(0, 0, 1, 1, 2'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0));
    send_tick(mk_tick(0, 0, 1, 1, 2'd1, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF));
    send_tick(mk_tick(0, 0, 1, 1, 2'd3, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A));
    send_tick(mk_tick(0, 1, 0, 1, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF));
    send_tick(mk_tick(0, 1, 1, 0, 2'd1, 64'h0, 64'h0));
    send_tick(mk_tick(0, 1, 1, 1, 2'd2, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210));
    send_tick(mk_tick(1, 1, 1, 1, 2'd2, 64'h1, 64'h2));
    send_tick(mk_tick(1, 0, 0, 0, 2'd0, 64'h0, 64'h0));
    send_tick(mk_tick(0, 1, 1, 0, 2'd2, 64'h0, 64'h0));
  endtask

  // Fill to the full 16 entries, hit the overflow stall, then flush a queue holding 15 entries.
  task automatic test_fill_to_capacity();
    repeat (8) send_tick(mk_tick(0, 0, 1, 1, 2'd2, {$urandom, $urandom}, {$urandom, $urandom}));
    send_tick(mk_tick(0, 0, 1, 1, 2'd2, 64'hDEAD_0000_0000_BEEF, 64'h1));
    send_tick(mk_tick(0, 1, 1, 1, 2'd1, 64'hCAFE_0000_0000_F00D, 64'h2));
    send_tick(mk_tick(1, 1, 1, 1, 2'd2, 64'h3, 64'h4));
  endtask

  // Random ticks under a range of register settings, extremes included.
  task automatic test_register_sweep();
    logic [4:0] caps [8] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd1, 5'd17, 5'd5, 5'd16};
    logic [1:0] pws  [8] = '{2'd2, 2'd2, 2'd3, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2};
    logic [1:0] dws  [8] = '{2'd2, 2'd2, 2'd3, 2'd1, 2'd1, 2'd0, 2'd2, 2'd1};
    for (int k = 0; k < 8; k++) begin
      apply_setting(caps[k], pws[k], dws[k]);
      // alternate slow and fast draining so some phases run full
      repeat (65) send_tick(random_tick((k % 2) ? 90 : 45));
    end
  endtask

  // Stall the sink for a long stretch while the source keeps pushing.
  task automatic test_sink_holdoff();
    src_idle_pct = 0;
    hold_requests++;
    repeat (50) send_tick(random_tick(90));
    src_idle_pct = 17;
  endtask

  // Back-to-back beats on both sides with no idling at all.
  task automatic test_unbroken_stream();
    apply_setting(5'd16, 2'd2, 2'd2);
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (80) send_tick(random_tick(70));
    src_idle_pct  = 17;
    sink_idle_pct = 17;
  endtask

  // Sink side: random back-pressure, plus a counted hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served    = hold_requests;
        sink_hold_left = SinkHoldCycles;
      end
      if (sink_hold_left != 0) begin
        sink_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Compare each accepted beat against the oldest prediction.
  always @(posedge clk_i) begin : beat_check
    decode_beat_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[0], m_axis_tdata[2:1], m_axis_tdata[66:3], m_axis_tdata[130:67],
              m_axis_tdata[131], m_axis_tdata[132], m_axis_tdata[133],
              m_axis_tdata[138:134], m_axis_tdata[143:139]};
      if (decode_beats_due.size() == 0) begin
        error_count++;
        $display("%0t: unexpected beat, expected none, actual %0h", $time, m_axis_tdata);
      end else begin
        want = decode_beats_due[0];
        decode_beats_due.delete(0);
        check_field("out_valid",      64'(want.out_valid),      64'(got.out_valid));
        check_field("out_count",      64'(want.out_count),      64'(got.out_count));
        check_field("out_entry0",     want.out_entry0,          got.out_entry0);
        check_field("out_entry1",     want.out_entry1,          got.out_entry1);
        check_field("accept_ready",   64'(want.accept_ready),   64'(got.accept_ready));
        check_field("took_input",     64'(want.took_input),     64'(got.took_input));
        check_field("overflow_stall", 64'(want.overflow_stall), 64'(got.overflow_stall));
        check_field("occupancy",      64'(want.occupancy),      64'(got.occupancy));
        check_field("peak_occupancy", 64'(want.peak_occupancy), 64'(got.peak_occupancy));
        beats_checked++;
        if (got.overflow_stall) stall_beats++;
      end
    end
  end

  // Watchdog: end the run if it never drains.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles, %0d beats still due", $time, cycle_count,
             decode_beats_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_fill_to_capacity();
    test_register_sweep();
    test_sink_holdoff();
    test_unbroken_stream();
    wait_queue_idle();

    $display("Covered %0d ticks (%0d flushes) over %0d register settings.",
             ticks_sent, flush_ticks, settings_used);
    $display("Checked %0d decode beats, %0d with fetch refused, %0d mismatches.",
             beats_checked, stall_beats, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
